// ===== rtl/core/sraf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sraf_pkg;

  localparam int MaxFrames  = 4096;
  localparam int MaxDims    = 64;
  localparam int NumRegions = 5;
  localparam int SumW       = 36;
  localparam int ValW       = 24;
  localparam int FrameW     = 12;
  localparam int CntW       = 13;
  localparam int DimW       = 6;
  localparam int AddrW      = $clog2(MaxDims);
  localparam int RegionW    = 3;
  localparam int DivW       = 11;
  localparam int StepW      = 6;
  localparam int CfgIdxW    = 3;
  localparam int DurW       = 5;

  typedef enum logic [1:0] {
    REQ_ELEM  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [CfgIdxW-1:0] CFG_NUM_FRAMES = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEG_START  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEG_END    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DIM  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LAST_DIM   = 3'd4;

  localparam logic [RegionW-1:0] RGN_FIRST  = 3'd0;
  localparam logic [RegionW-1:0] RGN_MIDDLE = 3'd1;
  localparam logic [RegionW-1:0] RGN_LAST   = 3'd2;
  localparam logic [RegionW-1:0] RGN_START  = 3'd3;
  localparam logic [RegionW-1:0] RGN_END    = 3'd4;

  localparam logic [DurW-1:0] DUR_OTHER = 5'd21;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
    logic wr_en;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic div_done;
    logic out_free;
  } stat_t;

  // floor(x/10) for x below 43690, by reciprocal multiply
  function automatic logic [12:0] div10(input logic [14:0] x);
    logic [31:0] p;
    p = {17'd0, x} * 32'd52429;
    return p[31:19];
  endfunction

  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                    input logic signed [ValW-1:0] v);
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {{(SumW+1-ValW){v[ValW-1]}}, v};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return s[SumW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sraf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sraf_ram #(
  parameter int Width = 36,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sraf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sraf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire sraf_pkg::stat_t stat,
  output sraf_pkg::cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC1 = 6'b000010,
    ST_CALC2 = 6'b000100,
    ST_UPD   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   init_r, init_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = 1'b0;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC1;
        end
      end
      ST_CALC1: begin
        if (stat.req == sraf_pkg::REQ_CLEAR) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.req == sraf_pkg::REQ_NONE) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_CALC2;
        end
      end
      ST_CALC2: begin
        if (stat.req == sraf_pkg::REQ_ELEM) begin
          state_nxt = ST_UPD;
        end else begin
          init_nxt  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_UPD: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (init_r) begin
          cmd.div_init = 1'b1;
        end else if (stat.div_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/sraf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sraf_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sraf_pkg::cmd_t                      cmd,
  output sraf_pkg::stat_t                          stat,
  input  wire logic [1:0]                          in_req,
  input  wire logic [sraf_pkg::FrameW-1:0]         in_frame,
  input  wire logic [sraf_pkg::DimW-1:0]           in_dim,
  input  wire logic signed [sraf_pkg::ValW-1:0]    in_sample,
  input  wire logic [sraf_pkg::RegionW-1:0]        in_region,
  input  wire logic                                cfg_we,
  input  wire logic [sraf_pkg::CfgIdxW-1:0]        cfg_idx,
  input  wire logic [sraf_pkg::CntW-1:0]           cfg_wdata,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [sraf_pkg::ValW-1:0]         out_avg,
  output logic [sraf_pkg::DurW-1:0]                out_dur
);

  localparam int SumW = sraf_pkg::SumW;
  localparam int CntW = sraf_pkg::CntW;
  localparam int DivW = sraf_pkg::DivW;
  localparam int NR   = sraf_pkg::NumRegions;

  // input item and configuration
  sraf_pkg::req_t                       req_r;
  logic [sraf_pkg::FrameW-1:0]          frame_r;
  logic [sraf_pkg::DimW-1:0]            dim_r;
  logic signed [sraf_pkg::ValW-1:0]     sample_r;
  logic [sraf_pkg::RegionW-1:0]         region_r;
  logic [CntW-1:0]                      nf_r, se_r;
  logic [sraf_pkg::FrameW-1:0]          ss_r;
  logic [sraf_pkg::DimW-1:0]            fd_r, ld_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= sraf_pkg::req_t'(in_req);
      frame_r  <= in_frame;
      dim_r    <= in_dim;
      sample_r <= in_sample;
      region_r <= in_region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= '0;
      ss_r <= '0;
      se_r <= '0;
      fd_r <= '0;
      ld_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sraf_pkg::CFG_NUM_FRAMES: nf_r <= cfg_wdata;
        sraf_pkg::CFG_SEG_START:  ss_r <= cfg_wdata[sraf_pkg::FrameW-1:0];
        sraf_pkg::CFG_SEG_END:    se_r <= cfg_wdata;
        sraf_pkg::CFG_FIRST_DIM:  fd_r <= cfg_wdata[sraf_pkg::DimW-1:0];
        sraf_pkg::CFG_LAST_DIM:   ld_r <= cfg_wdata[sraf_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // stage one: bounds, size, offset, windows
  logic [CntW-1:0] n_c, end_c, ss_c, frm_c, size_c;
  logic [CntW-1:0] slo_c, shi_c, elo_c, ehi_c;
  logic [CntW-1:0] size_r;
  logic signed [CntW:0] off_r;
  logic elem_ok_r, dim_ok_r, win_s_r, win_e_r;

  always_comb begin
    n_c    = (nf_r > CntW'(sraf_pkg::MaxFrames)) ? CntW'(sraf_pkg::MaxFrames) : nf_r;
    end_c  = (se_r < n_c) ? se_r : n_c;
    ss_c   = {1'b0, ss_r};
    frm_c  = {1'b0, frame_r};
    size_c = (end_c > ss_c) ? end_c - ss_c : '0;
    slo_c  = (ss_c >= CntW'(2)) ? ss_c - CntW'(2) : '0;
    shi_c  = (ss_c + CntW'(2) < n_c) ? ss_c + CntW'(2) : n_c;
    elo_c  = (end_c >= CntW'(2)) ? end_c - CntW'(2) : '0;
    ehi_c  = (end_c + CntW'(2) < n_c) ? end_c + CntW'(2) : n_c;
  end

  always_ff @(posedge clk) begin
    size_r    <= size_c;
    off_r     <= $signed({1'b0, frm_c}) - $signed({1'b0, ss_c});
    dim_ok_r  <= (dim_r >= fd_r) && (dim_r <= ld_r);
    elem_ok_r <= (frm_c < n_c) && (dim_r >= fd_r) && (dim_r <= ld_r);
    win_s_r   <= (frm_c >= slo_c) && (frm_c < shi_c);
    win_e_r   <= (frm_c >= elo_c) && (frm_c < ehi_c);
  end

  // stage two: region thresholds
  logic [12:0] t3_r, t4_r, t7_r;
  logic lt3_r, lt7_r, ltsz_r;
  logic signed [CntW+5:0] off10_c;
  logic [14:0] s3_c, s4_c, s7_c;

  always_comb begin
    off10_c = (CntW+6)'(off_r) * (CntW+6)'(10);
    s3_c    = 15'(size_r) * 15'd3;
    s4_c    = 15'(size_r) * 15'd4;
    s7_c    = 15'(size_r) * 15'd7;
  end

  always_ff @(posedge clk) begin
    t3_r   <= sraf_pkg::div10(s3_c);
    t4_r   <= sraf_pkg::div10(s4_c);
    t7_r   <= sraf_pkg::div10(s7_c);
    lt3_r  <= off10_c < $signed({4'd0, s3_c});
    lt7_r  <= off10_c < $signed({4'd0, s7_c});
    ltsz_r <= off_r < $signed({1'b0, size_r});
  end

  // sum memories, one per region; a row not written since clear reads as zero
  logic [sraf_pkg::MaxDims-1:0]   vld_r;
  logic [SumW-1:0]                rd_data [NR];
  logic [SumW-1:0]                wr_data [NR];
  logic [NR-1:0]                  hit;
  logic                           we;

  always_comb begin
    hit[0] = !off_r[CntW] && ltsz_r && lt3_r;
    hit[1] = (off_r >= $signed({1'b0, t3_r})) && lt7_r;
    hit[2] = (off_r >= $signed({1'b0, t7_r})) && ltsz_r;
    hit[3] = win_s_r;
    hit[4] = win_e_r;
    we     = cmd.wr_en && elem_ok_r;
  end

  for (genvar g = 0; g < NR; g++) begin : g_rgn
    logic signed [SumW-1:0] old;
    assign old        = vld_r[dim_r] ? rd_data[g] : '0;
    assign wr_data[g] = hit[g] ? sraf_pkg::sat_add(old, sample_r) : old;
    sraf_ram #(.Width(SumW), .Depth(sraf_pkg::MaxDims)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (dim_r[sraf_pkg::AddrW-1:0]),
      .wdata (wr_data[g]),
      .re    (cmd.rd_en),
      .raddr (dim_r[sraf_pkg::AddrW-1:0]),
      .rdata (rd_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[dim_r] <= 1'b1;
    end
  end

  // read: restoring divider, one quotient bit per cycle
  logic [SumW-1:0]           sel_c, mag_c;
  logic [DivW-1:0]           dvs_c, div_r, rem_r;
  logic [SumW-1:0]           dq_r;
  logic [sraf_pkg::StepW-1:0] cnt_r;
  logic                      sign_r, rd_ok_c;
  logic [DivW:0]             trial_c, diff_c;

  always_comb begin
    case (region_r)
      sraf_pkg::RGN_FIRST:  sel_c = rd_data[0];
      sraf_pkg::RGN_MIDDLE: sel_c = rd_data[1];
      sraf_pkg::RGN_LAST:   sel_c = rd_data[2];
      sraf_pkg::RGN_START:  sel_c = rd_data[3];
      sraf_pkg::RGN_END:    sel_c = rd_data[4];
      default:              sel_c = '0;
    endcase
    rd_ok_c = (size_r != '0) && (region_r <= sraf_pkg::RGN_END) && dim_ok_r
              && vld_r[dim_r];
    if (!rd_ok_c) begin
      sel_c = '0;
    end
    mag_c = sel_c[SumW-1] ? (~sel_c + SumW'(1)) : sel_c;
    case (region_r)
      sraf_pkg::RGN_FIRST, sraf_pkg::RGN_LAST: dvs_c = t3_r[DivW-1:0] + DivW'(1);
      sraf_pkg::RGN_MIDDLE:                    dvs_c = t4_r[DivW-1:0] + DivW'(1);
      default:                                 dvs_c = DivW'(4);
    endcase
    trial_c = {rem_r, dq_r[SumW-1]};
    diff_c  = trial_c - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq_r   <= mag_c;
      rem_r  <= '0;
      div_r  <= dvs_c;
      sign_r <= sel_c[SumW-1];
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      if (!diff_c[DivW]) begin
        rem_r <= diff_c[DivW-1:0];
        dq_r  <= {dq_r[SumW-2:0], 1'b1};
      end else begin
        rem_r <= trial_c[DivW-1:0];
        dq_r  <= {dq_r[SumW-2:0], 1'b0};
      end
      cnt_r <= cnt_r + sraf_pkg::StepW'(1);
    end
  end

  // result register
  logic signed [sraf_pkg::ValW-1:0] avg_c;
  logic [sraf_pkg::DurW-1:0]        dur_c;

  always_comb begin
    if (sign_r) begin
      avg_c = (dq_r > SumW'(24'h800000)) ? 24'sh800000 : -$signed(dq_r[23:0]);
    end else begin
      avg_c = (dq_r > SumW'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(dq_r[23:0]);
    end
    dur_c = (size_r != '0 && size_r <= CntW'(20)) ? size_r[sraf_pkg::DurW-1:0]
                                                  : sraf_pkg::DUR_OTHER;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg <= avg_c;
      out_dur <= dur_c;
    end
  end

  assign stat.req      = req_r;
  assign stat.div_done = (cnt_r == sraf_pkg::StepW'(SumW));
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/core/segment_region_average_features.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one item at a time: the block takes a new item only once it is through with the last;
// a read request runs the one-bit-per-cycle sum divider and then waits until
// the output register is free; a clear goes back to idle as soon as it is decoded
// a result waits in the output register while new items enter
// synchronous active-low reset clears control, configuration and the row
// valid bits, so every sum reads as zero right after reset with no sweep
module segment_region_average_features (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] frame_index, [17:12] dim_index, [41:18] sample_value, [47:42] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] req_type, [4:2] region
  input  wire logic [4:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [23:0] avg_value, [28:24] duration_code, [31:29] zero
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  sraf_pkg::cmd_t  cmd;
  sraf_pkg::stat_t stat;
  logic signed [sraf_pkg::ValW-1:0] avg;
  logic [sraf_pkg::DurW-1:0]        dur;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  sraf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sraf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_tuser[1:0]),
    .in_frame  (in_tdata[11:0]),
    .in_dim    (in_tdata[17:12]),
    .in_sample (in_tdata[41:18]),
    .in_region (in_tuser[4:2]),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_avg   (avg),
    .out_dur   (dur)
  );

  // pack result fields: average lowest, then duration code, zero pad on top
  assign out_tdata = {3'b000, dur, avg};

endmodule
`default_nettype wire

// ===== tb/segment_region_average_features_tb.sv =====
`timescale 1ns / 1ps
module segment_region_average_features_tb;

  localparam int  HalfPeriod = 6;
  localparam int  SettleCycles = 60;
  localparam int  StallLimit = 4000;    // cycles with no transfer on any channel
  localparam longint SumHi = 64'sd34359738367;
  localparam longint SumLo = -64'sd34359738368;
  localparam longint AvgHi = 64'sd8388607;
  localparam longint AvgLo = -64'sd8388608;

  typedef struct {
    sraf_pkg::req_t    req;
    logic [11:0]       frame;
    logic [5:0]        dim;
    logic signed [23:0] val;
    logic [2:0]        region;
  } feat_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  // stimulus waiting to be sent, and averages still owed by the block
  feat_item_t  pending_items[$];
  logic [31:0] owed_averages[$];

  // local copy of the block's configuration and sums
  longint cur_frames, cur_start, cur_end, cur_first, cur_last;
  longint region_sum [sraf_pkg::NumRegions][sraf_pkg::MaxDims];

  int  errors;
  int  reads_checked;
  int  items_sent;
  bit  idle_on;
  bit  in_fire;
  int  in_gap;
  int  out_gap;
  int  quiet_cycles;

  segment_region_average_features uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [11:0] frame, [17:12] dim, [41:18] value, [47:42] zero
    .in_tuser  (in_tuser),    // [1:0] req_type, [4:2] region
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [23:0] avg_value, [28:24] duration_code, [31:29] zero
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // segment length after clamping the end to the utterance
  function automatic longint seg_len();
    longint n, e;
    n = (cur_frames > sraf_pkg::MaxFrames) ? sraf_pkg::MaxFrames : cur_frames;
    e = (cur_end < n) ? cur_end : n;
    return (e > cur_start) ? e - cur_start : 0;
  endfunction

  function automatic bit near(longint f, longint c, longint n);
    longint lo, hi;
    lo = (c - 2 < 0) ? 0 : c - 2;
    hi = (c + 2 > n) ? n : c + 2;
    return f >= lo && f < hi;
  endfunction

  function automatic void accumulate(int r, int d, longint v);
    longint s;
    s = region_sum[r][d] + v;
    if (s > SumHi) s = SumHi;
    if (s < SumLo) s = SumLo;
    region_sum[r][d] = s;
  endfunction

  function automatic void clear_sums();
    for (int r = 0; r < sraf_pkg::NumRegions; r++)
      for (int d = 0; d < sraf_pkg::MaxDims; d++) region_sum[r][d] = 0;
  endfunction

  // advance the local copy by one accepted item; queue the average a read returns
  function automatic void track_item(feat_item_t it);
    longint size, n, e, o, f, d, dv, avg;
    logic [4:0] code;
    size = seg_len();
    n = (cur_frames > sraf_pkg::MaxFrames) ? sraf_pkg::MaxFrames : cur_frames;
    e = (cur_end < n) ? cur_end : n;
    f = it.frame;
    d = it.dim;
    o = f - cur_start;
    case (it.req)
      sraf_pkg::REQ_ELEM: begin
        if (f < n && d >= cur_first && d <= cur_last) begin
          if (o >= 0 && o < size && 10 * o < 3 * size)
            accumulate(sraf_pkg::RGN_FIRST, d, it.val);
          if (o >= (3 * size) / 10 && 10 * o < 7 * size)
            accumulate(sraf_pkg::RGN_MIDDLE, d, it.val);
          if (o >= (7 * size) / 10 && o < size)
            accumulate(sraf_pkg::RGN_LAST, d, it.val);
          if (near(f, cur_start, n)) accumulate(sraf_pkg::RGN_START, d, it.val);
          if (near(f, e, n)) accumulate(sraf_pkg::RGN_END, d, it.val);
        end
      end
      sraf_pkg::REQ_READ: begin
        avg = 0;
        code = (size >= 1 && size <= 20) ? 5'(size) : sraf_pkg::DUR_OTHER;
        if (size > 0 && it.region < sraf_pkg::NumRegions && d >= cur_first
            && d <= cur_last) begin
          if (it.region == sraf_pkg::RGN_FIRST || it.region == sraf_pkg::RGN_LAST)
            dv = (3 * size) / 10 + 1;
          else if (it.region == sraf_pkg::RGN_MIDDLE) dv = (4 * size) / 10 + 1;
          else dv = 4;
          avg = region_sum[it.region][d] / dv;
          if (avg > AvgHi) avg = AvgHi;
          if (avg < AvgLo) avg = AvgLo;
        end
        owed_averages.insert(owed_averages.size(), {3'b000, code, avg[23:0]});
      end
      sraf_pkg::REQ_CLEAR: clear_sums();
      default: ;
    endcase
  endfunction

  task automatic add_item(sraf_pkg::req_t req, int frame, int dim, int val, int region);
    feat_item_t it;
    it.req = req;
    it.frame = frame[11:0];
    it.dim = dim[5:0];
    it.val = val[23:0];
    it.region = region[2:0];
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[12:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sraf_pkg::CFG_NUM_FRAMES: cur_frames = value & 16'h1FFF;
      sraf_pkg::CFG_SEG_START:  cur_start = value & 16'h0FFF;
      sraf_pkg::CFG_SEG_END:    cur_end = value & 16'h1FFF;
      sraf_pkg::CFG_FIRST_DIM:  cur_first = value & 8'h3F;
      sraf_pkg::CFG_LAST_DIM:   cur_last = value & 8'h3F;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_segment(int nf, int ss, int se, int fd, int ld);
    write_reg(sraf_pkg::CFG_NUM_FRAMES, nf);
    write_reg(sraf_pkg::CFG_SEG_START, ss);
    write_reg(sraf_pkg::CFG_SEG_END, se);
    write_reg(sraf_pkg::CFG_FIRST_DIM, fd);
    write_reg(sraf_pkg::CFG_LAST_DIM, ld);
  endtask

  // sender holds off until the block has drained and gone quiet
  task automatic drain();
    wait (pending_items.size() == 0 && !in_tvalid && owed_averages.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // random traffic around the configured segment, mostly elements
  task automatic random_traffic(int count);
    int k, pick, f, d, v, lo, hi;
    lo = cur_start - 3;
    if (lo < 0) lo = 0;
    hi = cur_end + 3;
    if (hi > 4095) hi = 4095;
    if (hi < lo) hi = lo;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      f = ($urandom_range(9) == 0) ? $urandom : $urandom_range(hi, lo);
      d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(cur_last, cur_first);
      v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(131072) - 65536;
      if (pick < 78) add_item(sraf_pkg::REQ_ELEM, f, d, v, $urandom);
      else if (pick < 95) add_item(sraf_pkg::REQ_READ, $urandom, d, $urandom,
                                   ($urandom_range(7) == 0) ? $urandom : $urandom_range(4));
      else if (pick < 97) add_item(sraf_pkg::REQ_CLEAR, $urandom, $urandom, $urandom,
                                   $urandom);
      else add_item(sraf_pkg::REQ_NONE, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // sender: present the queue head, with random gaps between transfers
  always @(negedge clk) begin
    if (in_fire) begin
      void'(pending_items.pop_front());
      items_sent <= items_sent + 1;
    end
    if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;      // hold until accepted
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      in_gap <= $urandom_range(3);
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      feat_item_t nx;
      nx = pending_items[0];
      in_tvalid <= 1'b1;
      in_tdata <= {6'b0, nx.val, nx.dim, nx.frame};
      in_tuser <= {nx.region, nx.req};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(4) == 0) begin
      out_gap <= $urandom_range(3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: track accepted items, check each result transfer
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      feat_item_t seen;
      seen.frame = in_tdata[11:0];
      seen.dim = in_tdata[17:12];
      seen.val = in_tdata[41:18];
      seen.req = sraf_pkg::req_t'(in_tuser[1:0]);
      seen.region = in_tuser[4:2];
      track_item(seen);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_averages.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, out_tdata);
        errors <= errors + 1;
      end else begin
        logic [31:0] want;
        want = owed_averages.pop_front();
        if (out_tdata[23:0] !== want[23:0]) begin
          $display("%0t: avg_value expected %0d actual %0d", $time,
                   $signed(want[23:0]), $signed(out_tdata[23:0]));
          errors <= errors + 1;
        end
        if (out_tdata[28:24] !== want[28:24]) begin
          $display("%0t: duration_code expected %0d actual %0d", $time,
                   want[28:24], out_tdata[28:24]);
          errors <= errors + 1;
        end
        if (out_tdata[31:29] !== 3'b000) begin
          $display("%0t: pad bits expected 0 actual %b", $time, out_tdata[31:29]);
          errors <= errors + 1;
        end
        reads_checked <= reads_checked + 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int p, nf, ss, se, fd, ld;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_fire = 1'b0;
    in_gap = 0;
    out_gap = 0;
    quiet_cycles = 0;
    errors = 0;
    reads_checked = 0;
    items_sent = 0;
    idle_on = 1'b1;
    cur_frames = 0; cur_start = 0; cur_end = 0; cur_first = 0; cur_last = 0;
    clear_sums();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: ten-frame segment, extreme values and dims, every region
    set_segment(20, 3, 13, 0, 63);
    add_item(sraf_pkg::REQ_READ, 0, 0, 0, sraf_pkg::RGN_FIRST);   // sums start at zero
    add_item(sraf_pkg::REQ_ELEM, 0, 0, 8388607, 0);
    add_item(sraf_pkg::REQ_ELEM, 1, 63, -8388608, 7);
    add_item(sraf_pkg::REQ_ELEM, 3, 0, 8388607, 0);
    add_item(sraf_pkg::REQ_ELEM, 6, 63, -8388608, 0);
    add_item(sraf_pkg::REQ_ELEM, 10, 0, -1, 0);
    add_item(sraf_pkg::REQ_ELEM, 12, 63, 65536, 0);
    add_item(sraf_pkg::REQ_ELEM, 14, 0, 12345, 0);
    add_item(sraf_pkg::REQ_ELEM, 19, 0, 777, 0);
    add_item(sraf_pkg::REQ_ELEM, 20, 0, 8388607, 0);            // beyond the utterance
    add_item(sraf_pkg::REQ_ELEM, 4095, 63, 8388607, 0);
    add_item(sraf_pkg::REQ_NONE, 4095, 63, -1, 7);
    for (int r = 0; r < 8; r++) add_item(sraf_pkg::REQ_READ, 0, (r & 1) ? 63 : 0, 0, r);
    add_item(sraf_pkg::REQ_CLEAR, 0, 0, 0, 0);
    add_item(sraf_pkg::REQ_READ, 0, 0, 0, sraf_pkg::RGN_START);
    drain();

    // empty segment, then a narrow dimension range
    set_segment(30, 10, 5, 0, 63);
    add_item(sraf_pkg::REQ_ELEM, 10, 4, 1000, 0);
    add_item(sraf_pkg::REQ_READ, 0, 4, 0, sraf_pkg::RGN_START);
    add_item(sraf_pkg::REQ_READ, 0, 4, 0, sraf_pkg::RGN_MIDDLE);
    drain();
    set_segment(30, 2, 22, 5, 10);
    add_item(sraf_pkg::REQ_ELEM, 2, 4, 5000, 0);
    add_item(sraf_pkg::REQ_ELEM, 2, 5, 5000, 0);
    add_item(sraf_pkg::REQ_ELEM, 2, 11, 5000, 0);
    add_item(sraf_pkg::REQ_READ, 0, 4, 0, sraf_pkg::RGN_FIRST);
    add_item(sraf_pkg::REQ_READ, 0, 5, 0, sraf_pkg::RGN_FIRST);
    add_item(sraf_pkg::REQ_READ, 0, 11, 0, sraf_pkg::RGN_START);
    drain();

    // random phases; the last ones without idling, extremes among them
    for (p = 0; p < 14; p++) begin
      if (p == 0) begin
        nf = 8191; ss = 0; se = 8191; fd = 0; ld = 63;
      end else if (p == 1) begin
        nf = 4096; ss = 4095; se = 4096; fd = 63; ld = 63;
      end else if (p == 2) begin
        nf = 0; ss = 0; se = 0; fd = 0; ld = 0;
      end else begin
        nf = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(48);
        ss = $urandom_range(nf > 4095 ? 4095 : nf);
        se = ss + $urandom_range(26) - 3;
        if (se < 0) se = 0;
        fd = $urandom_range(8);
        ld = ($urandom_range(7) == 0) ? $urandom_range(63) : fd + $urandom_range(6);
      end
      idle_on = (p < 11);
      set_segment(nf, ss, se, fd, ld);
      random_traffic(p < 3 ? 40 : 100);
      drain();
    end

    // average saturation: one dimension driven past both 24-bit limits
    idle_on = 1'b1;
    set_segment(8, 2, 6, 0, 0);
    for (int k = 0; k < 12; k++) add_item(sraf_pkg::REQ_ELEM, 3, 0, 8388607, 0);
    for (int r = 0; r < sraf_pkg::NumRegions; r++) add_item(sraf_pkg::REQ_READ, 0, 0, 0, r);
    add_item(sraf_pkg::REQ_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < 12; k++) add_item(sraf_pkg::REQ_ELEM, 3, 0, -8388608, 0);
    for (int r = 0; r < sraf_pkg::NumRegions; r++) add_item(sraf_pkg::REQ_READ, 0, 0, 0, r);
    idle_on = 1'b0;
    drain();

    $display("covered %0d item transfers and %0d checked region averages", items_sent,
             reads_checked);
    $display("segment settings included empty, full-utterance and saturated averages");
    if (errors == 0 && owed_averages.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sraf_pkg.sv
rtl/core/sraf_ram.sv
rtl/core/sraf_ctrl.sv
rtl/core/sraf_dp.sv
rtl/core/segment_region_average_features.sv
tb/segment_region_average_features_tb.sv
